// ===== rtl/connection_slot_table_assert.svh =====
// ----------------------------------------------------------------------------
// Connection slot table assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_TABLE_ASSERT_SVH
`define CONNECTION_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property every clock, held off while reset is asserted
`define CST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("connection_slot_table assertion failed");
// Check a property every clock, reset cycles included
`define CST_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("connection_slot_table assertion failed");
`else
`define CST_ASSERT(label, prop)
`define CST_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// Connection slot table package
// Sizes, command and status codes, and shared types.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int DESC_BITS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int CAP_W     = 7;

  typedef logic [1:0]           cmd_t;
  typedef logic [1:0]           status_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [DESC_BITS-1:0] desc_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CAP_W-1:0]     cap_t;

  localparam cmd_t CMD_ALLOC   = 2'd0;
  localparam cmd_t CMD_RELEASE = 2'd1;
  localparam cmd_t CMD_LOOKUP  = 2'd2;
  localparam cmd_t CMD_REVERSE = 2'd3;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;

  localparam cap_t CAP_RESET = CAP_W'(MAX_SLOTS);

  // Result of one transaction, handed from the sequencer to the output stage
  typedef struct packed {
    status_t status;
    slot_t   slot;
    desc_t   desc;
    cnt_t    occupied;
  } res_t;

  // Descriptor store access for one cycle
  typedef struct packed {
    logic  we;
    slot_t waddr;
    desc_t wdata;
    slot_t raddr;
  } ram_req_t;

  // Clamp the capacity register to 1..MAX_SLOTS
  function automatic cnt_t eff_cap(input cap_t cap);
    cnt_t c;
    if (cap == '0) begin
      c = cnt_t'(1);
    end else if (32'(cap) > MAX_SLOTS) begin
      c = cnt_t'(MAX_SLOTS);
    end else begin
      c = cnt_t'(cap);
    end
    return c;
  endfunction

endpackage

// ===== rtl/cst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Connection slot table sequencer
// Holds the occupancy bits, rover and count, and steps one slot per cycle
// through allocation search and reverse lookup.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cst_pkg::cmd_t     in_cmd,
  input  cst_pkg::slot_t    in_slot,
  input  cst_pkg::desc_t    in_desc,
  input  cst_pkg::cnt_t     cap,
  output logic              res_valid,
  input  logic              res_ready,
  output cst_pkg::res_t     res,
  output cst_pkg::ram_req_t ram_req,
  input  cst_pkg::desc_t    ram_rdata
);
  import cst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RSCAN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;
  slot_t                rover_r, rover_nxt;
  cnt_t                 occ_r, occ_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;

  cmd_t    cmd_r, cmd_nxt;
  slot_t   slot_r, slot_nxt;
  desc_t   desc_r, desc_nxt;
  cnt_t    cap_r, cap_nxt;
  slot_t   pos_r, pos_nxt;
  slot_t   step_r, step_nxt;
  slot_t   idx_r, idx_nxt;
  slot_t   cmp_idx_r, cmp_idx_nxt;
  status_t st_r, st_nxt;
  slot_t   rslot_r, rslot_nxt;
  desc_t   rdesc_r, rdesc_nxt;

  cnt_t cap_m1;

  assign cap_m1    = cap_r - cnt_t'(1);
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{status: st_r, slot: rslot_r, desc: rdesc_r, occupied: occ_r};

  // Sequence one transaction
  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    rover_nxt   = rover_r;
    occ_nxt     = occ_r;
    cmp_vld_nxt = cmp_vld_r;
    cmd_nxt     = cmd_r;
    slot_nxt    = slot_r;
    desc_nxt    = desc_r;
    cap_nxt     = cap_r;
    pos_nxt     = pos_r;
    step_nxt    = step_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    st_nxt      = st_r;
    rslot_nxt   = rslot_r;
    rdesc_nxt   = rdesc_r;
    ram_req     = '{we: 1'b0, waddr: pos_r, wdata: desc_r, raddr: idx_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          slot_nxt  = in_slot;
          desc_nxt  = in_desc;
          cap_nxt   = cap;
          state_nxt = S_START;
        end
      end
      S_START: begin
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (occ_r >= cap_r) begin
              st_nxt    = ST_FULL;
              rslot_nxt = '0;
              rdesc_nxt = '0;
              state_nxt = S_DONE;
            end else begin
              // Start at the rover, or at slot zero if it lies past capacity
              pos_nxt   = (cnt_t'(rover_r) < cap_r) ? rover_r : '0;
              step_nxt  = '0;
              state_nxt = S_ALLOC;
            end
          end
          CMD_RELEASE, CMD_LOOKUP: begin
            if ((cnt_t'(slot_r) >= cap_r) || !valid_r[slot_r]) begin
              st_nxt    = ST_MISS;
              rslot_nxt = '0;
              rdesc_nxt = '0;
              state_nxt = S_DONE;
            end else begin
              ram_req.raddr = slot_r;
              state_nxt     = S_READ;
            end
          end
          CMD_REVERSE: begin
            idx_nxt     = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_RSCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ALLOC: begin
        if (!valid_r[pos_r]) begin
          // Claim the free slot and park the rover on it
          ram_req.we       = 1'b1;
          valid_nxt[pos_r] = 1'b1;
          rover_nxt        = pos_r;
          occ_nxt          = occ_r + cnt_t'(1);
          st_nxt           = ST_OK;
          rslot_nxt        = pos_r;
          rdesc_nxt        = '0;
          state_nxt        = S_DONE;
        end else if (cnt_t'(step_r) == cap_m1) begin
          st_nxt    = ST_FULL;
          rslot_nxt = '0;
          rdesc_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          // Advance cyclically inside the active capacity
          pos_nxt  = ((cnt_t'(pos_r) + cnt_t'(1)) >= cap_r) ? '0 : pos_r + slot_t'(1);
          step_nxt = step_r + slot_t'(1);
        end
      end
      S_READ: begin
        if (cmd_r == CMD_RELEASE) begin
          valid_nxt[slot_r] = 1'b0;
          if (occ_r != '0) begin
            occ_nxt = occ_r - cnt_t'(1);
          end
        end
        st_nxt    = ST_OK;
        rslot_nxt = slot_r;
        rdesc_nxt = ram_rdata;
        state_nxt = S_DONE;
      end
      S_RSCAN: begin
        // Compare the slot read last cycle while the next read is issued
        if (cmp_vld_r && valid_r[cmp_idx_r] && (ram_rdata == desc_r)) begin
          st_nxt    = ST_OK;
          rslot_nxt = cmp_idx_r;
          rdesc_nxt = desc_r;
          state_nxt = S_DONE;
        end else if (cmp_vld_r && (cnt_t'(cmp_idx_r) == cap_m1)) begin
          st_nxt    = ST_MISS;
          rslot_nxt = '0;
          rdesc_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_r + slot_t'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      rover_r   <= '0;
      occ_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      rover_r   <= rover_nxt;
      occ_r     <= occ_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Transaction fields, scan pointers and result
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    slot_r    <= slot_nxt;
    desc_r    <= desc_nxt;
    cap_r     <= cap_nxt;
    pos_r     <= pos_nxt;
    step_r    <= step_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    st_r      <= st_nxt;
    rslot_r   <= rslot_nxt;
    rdesc_r   <= rdesc_nxt;
  end

endmodule

// ===== rtl/connection_slot_table.sv =====
// A release or lookup hit runs from accept through the start, read and done states; a
// miss or an already full table goes from start straight to done. Allocate steps from
// the rover slot by slot; reverse lookup scans up to capacity, one slot per cycle through
// the descriptor RAM port. One transaction at a time: the next is accepted in the cycle
// after the result is handed to the output register. Synchronous active-low reset frees
// all slots, clears rover and count, sets capacity to 64; descriptor RAM is not cleared.
// ----------------------------------------------------------------------------
// Connection slot table
// Slot allocator with round-robin rover, release, lookup and reverse lookup.
// ----------------------------------------------------------------------------
module connection_slot_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [cst_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [cst_pkg::SLOT_W-1:0] in_slot_in,
  input  logic [cst_pkg::DESC_BITS-1:0] in_descriptor_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [cst_pkg::SLOT_W-1:0] out_slot_out,
  output logic [cst_pkg::DESC_BITS-1:0] out_descriptor_out,
  output logic [cst_pkg::CNT_W-1:0]  out_occupied_count
);
  import cst_pkg::*;

  `include "connection_slot_table_assert.svh"

  cap_t     cap_r;
  logic     out_valid_r, out_valid_nxt;
  res_t     out_r;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  ram_req_t ram_req;
  desc_t    ram_rdata;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_slot   (in_slot_in),
    .in_desc   (in_descriptor_in),
    .cap       (eff_cap(cap_r)),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  cst_ram #(
    .WIDTH (DESC_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_slot_out       = out_r.slot;
  assign out_descriptor_out = out_r.desc;
  assign out_occupied_count = out_r.occupied;

  // Busy after every accepted transaction
  `CST_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
  // A handed-off result always shows up at the output
  `CST_ASSERT(a_result_lands, (res_valid && res_ready) |=> out_valid)
  // Failures carry zero slot and descriptor
  `CST_ASSERT(a_fail_zero, (out_valid && (out_status != ST_OK)) |->
    ((out_slot_out == '0) && (out_descriptor_out == '0)))
  // Reset empties the output stage
  `CST_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !out_valid)

endmodule
